@@ rtl/core/rgb_color_line_parser_core_macros.svh @@
// Assertion macros for the color line parser core.
// Needs nothing else; included by rgb_color_line_parser_core, which checks itself.
`ifndef RGB_COLOR_LINE_PARSER_CORE_MACROS_SVH
`define RGB_COLOR_LINE_PARSER_CORE_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define RGBCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rgbcp assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define RGBCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rgbcp assertion failed");

`endif

@@ rtl/core/rgbcp_pkg.sv @@
// Shared types and character constants for the color line parser core.
// No dependencies; used by rgbcp_step and rgb_color_line_parser_core.
`timescale 1ns / 1ps

package rgbcp_pkg;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] BYTE_MAX   = 8'hFF;

    typedef enum logic [4:0] {
        PH_IDENT = 5'b00001,
        PH_RED   = 5'b00010,
        PH_GREEN = 5'b00100,
        PH_BLUE  = 5'b01000,
        PH_TAIL  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_in_req;

    typedef struct packed {
        logic        ok;
        logic [31:0] color_word;
    } t_out_req;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] accumulator;
        logic       too_large;
        logic       digit_seen;
        logic [7:0] red_value;
        logic [7:0] green_value;
        logic       failed;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase:       PH_IDENT,
        accumulator: 8'd0,
        too_large:   1'b0,
        digit_seen:  1'b0,
        red_value:   8'd0,
        green_value: 8'd0,
        failed:      1'b0
    };

endpackage

@@ rtl/core/rgbcp_step.sv @@
// One character step of the color line parser: next parse state and line result.
// Depends on rgbcp_pkg.
`timescale 1ns / 1ps

module rgbcp_step (
    input  rgbcp_pkg::t_parse_state i_state,
    input  logic [7:0]              i_character,
    output rgbcp_pkg::t_parse_state o_state,
    output rgbcp_pkg::t_out_req     o_result
);

    logic        is_digit;
    logic        is_space;
    logic        is_blank;
    logic [3:0]  digit;
    logic [11:0] scaled;
    logic        over;
    logic        line_ok;

    assign is_digit = (i_character >= rgbcp_pkg::CH_ZERO) && (i_character <= rgbcp_pkg::CH_NINE);
    assign is_space = (i_character == rgbcp_pkg::CH_SPACE);
    assign is_blank = is_space || (i_character == rgbcp_pkg::CH_NEWLINE);
    assign digit    = 4'(i_character - rgbcp_pkg::CH_ZERO);
    assign scaled   = {1'b0, i_state.accumulator, 3'b000}
                    + {3'b000, i_state.accumulator, 1'b0}
                    + {8'd0, digit};
    assign over     = (scaled > 12'd255);

    always_comb begin
        o_state = i_state;
        if (!i_state.failed) begin
            unique case (i_state.phase)
                rgbcp_pkg::PH_IDENT: begin
                    o_state.phase       = rgbcp_pkg::PH_RED;
                    o_state.accumulator = 8'd0;
                    o_state.too_large   = 1'b0;
                    o_state.digit_seen  = 1'b0;
                end
                rgbcp_pkg::PH_TAIL: begin
                    if (!is_blank) begin
                        o_state.failed = 1'b1;
                    end
                end
                rgbcp_pkg::PH_RED, rgbcp_pkg::PH_GREEN, rgbcp_pkg::PH_BLUE: begin
                    priority if (is_digit) begin
                        o_state.accumulator = over ? rgbcp_pkg::BYTE_MAX : scaled[7:0];
                        o_state.too_large   = i_state.too_large || over;
                        o_state.digit_seen  = 1'b1;
                    end else if (!i_state.digit_seen) begin
                        if (!is_space) begin
                            o_state.failed = 1'b1;
                        end
                    end else if (i_state.too_large) begin
                        o_state.failed = 1'b1;
                    end else if (i_state.phase == rgbcp_pkg::PH_BLUE) begin
                        if (is_blank) begin
                            o_state.phase = rgbcp_pkg::PH_TAIL;
                        end else begin
                            o_state.failed = 1'b1;
                        end
                    end else if (i_character != rgbcp_pkg::CH_COMMA) begin
                        o_state.failed = 1'b1;
                    end else begin
                        if (i_state.phase == rgbcp_pkg::PH_RED) begin
                            o_state.red_value = i_state.accumulator;
                            o_state.phase     = rgbcp_pkg::PH_GREEN;
                        end else begin
                            o_state.green_value = i_state.accumulator;
                            o_state.phase       = rgbcp_pkg::PH_BLUE;
                        end
                        o_state.accumulator = 8'd0;
                        o_state.too_large   = 1'b0;
                        o_state.digit_seen  = 1'b0;
                    end
                end
                default: begin
                    o_state.failed = 1'b1;
                end
            endcase
        end
    end

    assign line_ok = !o_state.failed
                  && ((o_state.phase == rgbcp_pkg::PH_TAIL)
                   || ((o_state.phase == rgbcp_pkg::PH_BLUE)
                       && o_state.digit_seen && !o_state.too_large));

    assign o_result.ok         = line_ok;
    assign o_result.color_word = line_ok
        ? {o_state.red_value, o_state.green_value, o_state.accumulator, rgbcp_pkg::BYTE_MAX}
        : 32'd0;

endmodule

@@ rtl/core/rgb_color_line_parser_core.sv @@
// Top level of the color line parser core: parse state, result register, handshakes.
// Depends on rgbcp_pkg, rgbcp_step and rgb_color_line_parser_core_macros.svh.
`timescale 1ns / 1ps

// Parses one "X r,g,b" color line, one character per request, and returns one
// result request (ok flag and packed RGBA word, alpha 255) after the character
// marked last. A character is taken every cycle: the parse state register is
// updated by a single combinational step, and the line result is captured in an
// output register when the last character is taken. The input stalls only
// while that output register holds a result that the consumer has not taken.
// The state is cleared after every line; no clearing pass is needed after reset.
module rgb_color_line_parser_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rgbcp_pkg::t_in_req  i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rgbcp_pkg::t_out_req o_out_req
);

    rgbcp_pkg::t_parse_state r_state;
    rgbcp_pkg::t_parse_state n_state;
    rgbcp_pkg::t_parse_state step_state;
    rgbcp_pkg::t_out_req     step_result;
    rgbcp_pkg::t_out_req     r_out;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic                    in_fire;

    rgbcp_step u_step (
        .i_state     (r_state),
        .i_character (i_in_req.character),
        .o_state     (step_state),
        .o_result    (step_result)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        if (in_fire) begin
            if (i_in_req.last) begin
                n_state     = rgbcp_pkg::PARSE_RESET;
                n_out_valid = 1'b1;
            end else begin
                n_state = step_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rgbcp_pkg::PARSE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_in_req.last) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

`include "rgb_color_line_parser_core_macros.svh"

    `RGBCP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, in_fire && i_in_req.last, o_out_valid)
    `RGBCP_ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n, in_fire && i_in_req.last, r_state.phase == rgbcp_pkg::PH_IDENT && !r_state.failed)
    `RGBCP_ASSERT_NOW(a_fail_word_zero, i_clk, i_rst_n, o_out_valid && !o_out_req.ok, o_out_req.color_word == 32'd0)
    `RGBCP_ASSERT_NOW(a_ok_alpha_full, i_clk, i_rst_n, o_out_valid && o_out_req.ok, o_out_req.color_word[7:0] == rgbcp_pkg::BYTE_MAX)

endmodule

@@ tb/rgb_color_line_parser_core_checker.sv @@
// Checker for the color line parser core: watches both request channels,
// predicts each line result and compares it. Depends on rgbcp_pkg.
`timescale 1ns / 1ps

module rgb_color_line_parser_core_checker
    import rgbcp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_in_req  i_in_req,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_out_req i_out_req,
    output int       o_fail_count = 0,
    output int       o_pending = 0
);

    t_phase     line_phase;
    logic [7:0] value_acc;
    logic       over_range;
    logic       has_digit;
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic       line_broken;

    t_out_req   expected_colors[$];
    t_out_req   want;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("ERROR %0t: %s: got %h, expected %h", $time, what, got, exp_val);
        o_fail_count++;
    endtask

    task automatic clear_component();
        value_acc  = 8'd0;
        over_range = 1'b0;
        has_digit  = 1'b0;
    endtask

    task automatic clear_line();
        line_phase  = PH_IDENT;
        red_byte    = 8'd0;
        green_byte  = 8'd0;
        line_broken = 1'b0;
        clear_component();
    endtask

    task automatic parse_char(input logic [7:0] ch);
        int unsigned grown;
        if (!line_broken) begin
            case (line_phase)
                PH_IDENT: begin
                    line_phase = PH_RED;
                    clear_component();
                end
                PH_TAIL: begin
                    if (ch != CH_SPACE && ch != CH_NEWLINE)
                        line_broken = 1'b1;
                end
                default: begin
                    if (ch >= CH_ZERO && ch <= CH_NINE) begin
                        grown = value_acc * 10 + (ch - CH_ZERO);
                        if (grown > 255) begin
                            over_range = 1'b1;
                            grown = 255;
                        end
                        value_acc = grown[7:0];
                        has_digit = 1'b1;
                    end else if (!has_digit) begin
                        if (ch != CH_SPACE)
                            line_broken = 1'b1;
                    end else if (over_range) begin
                        line_broken = 1'b1;
                    end else if (line_phase == PH_BLUE) begin
                        if (ch == CH_SPACE || ch == CH_NEWLINE)
                            line_phase = PH_TAIL;
                        else
                            line_broken = 1'b1;
                    end else if (ch != CH_COMMA) begin
                        line_broken = 1'b1;
                    end else begin
                        if (line_phase == PH_RED) begin
                            red_byte   = value_acc;
                            line_phase = PH_GREEN;
                        end else begin
                            green_byte = value_acc;
                            line_phase = PH_BLUE;
                        end
                        clear_component();
                    end
                end
            endcase
        end
    endtask

    function automatic t_out_req line_color();
        t_out_req res;
        res.ok = !line_broken && (line_phase == PH_TAIL ||
                 (line_phase == PH_BLUE && has_digit && !over_range));
        res.color_word = res.ok ? {red_byte, green_byte, value_acc, BYTE_MAX} : 32'd0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            expected_colors.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch("result with no line pending", i_out_req.color_word,
                                    32'd0);
                end else begin
                    want = expected_colors.pop_front();
                    if (i_out_req.ok !== want.ok)
                        report_mismatch("ok flag", {31'd0, i_out_req.ok},
                                        {31'd0, want.ok});
                    if (i_out_req.color_word !== want.color_word)
                        report_mismatch("color word", i_out_req.color_word,
                                        want.color_word);
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_char(i_in_req.character);
                if (i_in_req.last) begin
                    expected_colors.push_back(line_color());
                    clear_line();
                end
            end
        end
        o_pending = expected_colors.size();
    end

endmodule

@@ tb/rgb_color_line_parser_core_test.sv @@
// Testbench top for the color line parser core: clock, reset, line stimulus,
// receiver stalls and verdict. Depends on rgbcp_pkg and the checker module.
`timescale 1ns / 1ps

module rgb_color_line_parser_core_test;
    import rgbcp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    t_in_req  in_req = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out_req out_req;

    int       fail_count;
    int       pending;
    int       cycle_count = 0;
    int       sender_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_len = 0;
    int       hold_left = 0;
    int       chars_sent = 0;
    logic [7:0] line_q[$];

    rgb_color_line_parser_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req)
    );

    rgb_color_line_parser_core_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_req    (out_req),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // hold off for a long stretch on request, else stall at random
    always @(negedge clk) begin
        if (hold_left == 0 && hold_len > 0) begin
            hold_left = hold_len;
            hold_len = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic lst);
        @(negedge clk);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{character: ch, last: lst};
        do @(posedge clk); while (!in_ready);
        chars_sent++;
    endtask

    task automatic send_line();
        for (int k = 0; k < line_q.size(); k++)
            send_char(line_q[k], k == line_q.size() - 1);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic load_text(input string txt);
        line_q.delete();
        for (int k = 0; k < txt.len(); k++)
            line_q.push_back(txt[k]);
    endtask

    task automatic push_number(input int unsigned val, input int unsigned zeros);
        string txt;
        txt = $sformatf("%0d", val);
        repeat (zeros) line_q.push_back(CH_ZERO);
        for (int k = 0; k < txt.len(); k++)
            line_q.push_back(txt[k]);
    endtask

    task automatic build_color_line();
        int unsigned roll;
        int unsigned val;
        line_q.delete();
        line_q.push_back(8'($urandom_range(255, 0)));
        for (int comp = 0; comp < 3; comp++) begin
            repeat ($urandom_range(2, 0)) line_q.push_back(CH_SPACE);
            roll = $urandom_range(99, 0);
            if (roll < 10)
                val = 0;
            else if (roll < 20)
                val = 255;
            else if (roll < 28)
                val = $urandom_range(999, 256);
            else
                val = $urandom_range(255, 0);
            push_number(val, ($urandom_range(99, 0) < 15) ? $urandom_range(3, 1) : 0);
            if (comp < 2)
                line_q.push_back(CH_COMMA);
        end
        repeat ($urandom_range(3, 0))
            line_q.push_back($urandom_range(1, 0) ? CH_SPACE : CH_NEWLINE);
    endtask

    task automatic break_line();
        int unsigned pos;
        pos = $urandom_range(line_q.size() - 1, 1);
        case ($urandom_range(4, 0))
            0: line_q[pos] = 8'($urandom_range(255, 0));
            1: line_q.delete(pos);
            2: line_q.insert(pos, 8'($urandom_range(255, 0)));
            3: begin
                for (int k = line_q.size() - 1; k > 0; k--) begin
                    if (line_q[k] == CH_COMMA)
                        pos = k;
                end
                line_q.insert(pos, CH_SPACE);
            end
            default: begin
                while (line_q.size() > pos)
                    void'(line_q.pop_back());
            end
        endcase
    endtask

    task automatic build_noise();
        line_q.delete();
        repeat ($urandom_range(12, 1)) begin
            if ($urandom_range(99, 0) < 40) begin
                case ($urandom_range(3, 0))
                    0: line_q.push_back(8'(CH_ZERO + $urandom_range(9, 0)));
                    1: line_q.push_back(CH_COMMA);
                    2: line_q.push_back(CH_SPACE);
                    default: line_q.push_back(CH_NEWLINE);
                endcase
            end else begin
                line_q.push_back(8'($urandom_range(255, 0)));
            end
        end
    endtask

    task automatic random_line();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 88) begin
            build_color_line();
            if (roll >= 70)
                break_line();
        end else begin
            build_noise();
        end
        send_line();
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int start_chars;
        int lines;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        start_chars = chars_sent;
        lines = 0;
        while (chars_sent - start_chars < 100 || lines < 8) begin
            random_line();
            lines++;
        end
        drain();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_text("A");
        send_line();
        load_text("C0,0,0");
        send_line();
        load_text("F255,255,255\n");
        send_line();
        load_text("x256,1,1");
        send_line();
        load_text("G");
        line_q.push_back(8'h00);
        send_line();
        drain();

        // stall the output for a long stretch while lines keep coming
        hold_len = 300;
        repeat (8) begin
            build_color_line();
            send_line();
        end
        drain();

        run_phase(0, 0);
        run_phase(84, 0);
        run_phase(0, 84);
        run_phase(36, 36);

        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
